### design/rset_pkg.sv
package rset_pkg;

  localparam int Capacity = 64;
  localparam int IdxW     = $clog2(Capacity);
  localparam int CntW     = $clog2(Capacity + 1);
  localparam int ValW     = 32;
  localparam int RndW     = 31;
  localparam int DivCntW  = $clog2(RndW);
  localparam int EcW      = 7;
  localparam int SInW     = 64;
  localparam int MOutW    = 40;

  typedef enum logic [1:0] {
    OpInsert = 2'd0,
    OpRemove = 2'd1,
    OpSample = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    StOk      = 3'd0,
    StPresent = 3'd1,
    StAbsent  = 3'd2,
    StFull    = 3'd3,
    StEmpty   = 3'd4
  } status_e;

  typedef struct packed {
    logic    load;
    logic    scan;
    logic    rd_last;
    logic    rd_smp;
    logic    append;
    logic    move;
    logic    div_step;
    logic    resp;
    logic    take_sample;
    status_e status;
  } cmd_t;

  typedef struct packed {
    logic found;
    logic exhausted;
    logic full;
    logic count_zero;
    logic div_last;
    logic out_free;
  } sts_t;

endpackage

### design/rset_dp.sv
module rset_dp import rset_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cmd_t               cmd_i,
  output sts_t               sts_o,
  input  logic [ValW-1:0]    item_value_i,
  input  logic [RndW-1:0]    random_word_i,
  output logic               m_axis_tvalid_o,
  input  logic               m_axis_tready_i,
  output logic [MOutW-1:0]   m_axis_tdata_o,
  output logic [2:0]         m_axis_tuser_o
);

  logic [ValW-1:0]    mem [Capacity];
  logic [ValW-1:0]    rd_data_q;
  logic [IdxW-1:0]    rd_addr;
  logic               rd_en;

  logic [CntW-1:0]    count_q, count_d;
  logic [CntW-1:0]    count_m1;
  logic [CntW-1:0]    scan_q, scan_d;
  logic               cmp_vld_q, cmp_vld_d;
  logic [IdxW-1:0]    cmp_idx_q;
  logic [IdxW-1:0]    slot_q;
  logic               issue;
  logic               found;

  logic [ValW-1:0]    val_q;
  logic [RndW-1:0]    rnd_q;
  logic [CntW-1:0]    rem_q;
  logic [DivCntW-1:0] div_cnt_q;
  logic [CntW:0]      trial;
  logic [CntW:0]      trial_sub;

  logic               out_vld_q;
  logic [ValW-1:0]    out_smp_q;
  logic [EcW-1:0]     out_cnt_q;
  status_e            out_st_q;
  logic [CntW+EcW-1:0] count_wide;

  assign count_m1 = count_q - CntW'(1);
  assign issue    = cmd_i.scan && (scan_q < count_q);
  assign found    = cmp_vld_q && (rd_data_q == val_q);
  assign rd_en    = issue || cmd_i.rd_last || cmd_i.rd_smp;

  always_comb begin
    priority if (cmd_i.rd_last) begin
      rd_addr = count_m1[IdxW-1:0];
    end else if (cmd_i.rd_smp) begin
      rd_addr = rem_q[IdxW-1:0];
    end else begin
      rd_addr = scan_q[IdxW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.append) begin
      mem[count_q[IdxW-1:0]] <= val_q;
    end else if (cmd_i.move) begin
      mem[slot_q] <= rd_data_q;
    end
    if (rd_en) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  always_comb begin
    count_d = count_q;
    if (cmd_i.append) begin
      count_d = count_q + CntW'(1);
    end else if (cmd_i.move) begin
      count_d = count_m1;
    end
  end

  always_comb begin
    scan_d    = scan_q;
    cmp_vld_d = 1'b0;
    if (cmd_i.load) begin
      scan_d = '0;
    end else if (issue) begin
      scan_d    = scan_q + CntW'(1);
      cmp_vld_d = 1'b1;
    end
  end

  assign trial     = {rem_q, rnd_q[RndW-1]};
  assign trial_sub = trial - {1'b0, count_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      scan_q    <= '0;
      cmp_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      count_q   <= count_d;
      scan_q    <= scan_d;
      cmp_vld_q <= cmp_vld_d;
      if (cmd_i.resp) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  assign count_wide = {{EcW{1'b0}}, count_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      val_q     <= item_value_i;
      rnd_q     <= random_word_i;
      rem_q     <= '0;
      div_cnt_q <= DivCntW'(RndW - 1);
    end else if (cmd_i.div_step) begin
      rnd_q     <= {rnd_q[RndW-2:0], 1'b0};
      rem_q     <= (trial >= {1'b0, count_q}) ? trial_sub[CntW-1:0] : trial[CntW-1:0];
      div_cnt_q <= div_cnt_q - DivCntW'(1);
    end
    if (issue) begin
      cmp_idx_q <= scan_q[IdxW-1:0];
    end
    if (cmd_i.scan && found) begin
      slot_q <= cmp_idx_q;
    end
    if (cmd_i.resp) begin
      out_st_q  <= cmd_i.status;
      out_smp_q <= cmd_i.take_sample ? rd_data_q : '0;
      out_cnt_q <= count_wide[EcW-1:0];
    end
  end

  assign sts_o.found      = found;
  assign sts_o.exhausted  = !cmp_vld_q && (scan_q == count_q);
  assign sts_o.full       = count_q >= CntW'(Capacity);
  assign sts_o.count_zero = count_q == '0;
  assign sts_o.div_last   = div_cnt_q == '0;
  assign sts_o.out_free   = !out_vld_q || m_axis_tready_i;

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {{(MOutW - ValW - EcW){1'b0}}, out_cnt_q, out_smp_q};
  assign m_axis_tuser_o  = out_st_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Capacity))
    else $error("entry count exceeds capacity");

  a_append_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.append |=> count_q == $past(count_q) + CntW'(1))
    else $error("append did not grow the count");

  a_found_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    found |-> cmp_idx_q < count_q)
    else $error("match reported beyond stored entries");

endmodule

### design/rset_ctrl.sv
module rset_ctrl import rset_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [1:0] op_i,
  input  sts_t       sts_i,
  output cmd_t       cmd_o
);

  typedef enum logic [7:0] {
    SIdle    = 8'b0000_0001,
    SSearch  = 8'b0000_0010,
    SRmRead  = 8'b0000_0100,
    SRmWrite = 8'b0000_1000,
    SDiv     = 8'b0001_0000,
    SSmpRead = 8'b0010_0000,
    SResp    = 8'b0100_0000,
    SRespSmp = 8'b1000_0000
  } state_e;

  state_e  state_q, state_d;
  op_e     op_q, op_d;
  status_e status_q, status_d;
  logic    accept;

  assign s_axis_tready_o = state_q == SIdle;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    state_d  = state_q;
    op_d     = op_q;
    status_d = status_q;
    cmd_o    = '0;
    cmd_o.status = status_q;
    unique case (state_q)
      SIdle: begin
        if (accept) begin
          cmd_o.load = 1'b1;
          op_d       = op_e'(op_i);
          status_d   = StOk;
          unique case (op_e'(op_i))
            OpInsert, OpRemove: state_d = SSearch;
            OpSample: begin
              if (sts_i.count_zero) begin
                status_d = StEmpty;
                state_d  = SResp;
              end else begin
                state_d = SDiv;
              end
            end
            default: state_d = SResp;
          endcase
        end
      end
      SSearch: begin
        cmd_o.scan = 1'b1;
        if (sts_i.found) begin
          if (op_q == OpInsert) begin
            status_d = StPresent;
            state_d  = SResp;
          end else begin
            state_d = SRmRead;
          end
        end else if (sts_i.exhausted) begin
          state_d = SResp;
          if (op_q == OpRemove) begin
            status_d = StAbsent;
          end else if (sts_i.full) begin
            status_d = StFull;
          end else begin
            cmd_o.append = 1'b1;
          end
        end
      end
      SRmRead: begin
        cmd_o.rd_last = 1'b1;
        state_d       = SRmWrite;
      end
      SRmWrite: begin
        cmd_o.move = 1'b1;
        state_d    = SResp;
      end
      SDiv: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = SSmpRead;
        end
      end
      SSmpRead: begin
        cmd_o.rd_smp = 1'b1;
        state_d      = SRespSmp;
      end
      SResp: begin
        if (sts_i.out_free) begin
          cmd_o.resp = 1'b1;
          state_d    = SIdle;
        end
      end
      SRespSmp: begin
        cmd_o.take_sample = 1'b1;
        if (sts_i.out_free) begin
          cmd_o.resp = 1'b1;
          state_d    = SIdle;
        end
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= SIdle;
      op_q     <= OpInsert;
      status_q <= StOk;
    end else begin
      state_q  <= state_d;
      op_q     <= op_d;
      status_q <= status_d;
    end
  end

  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q != SIdle)
    else $error("accepted transaction left controller idle");

  a_resp_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.resp |-> sts_i.out_free)
    else $error("result loaded over an untaken result");

  a_one_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_o.append && cmd_o.move))
    else $error("two store writes in one cycle");

endmodule

### design/randomized_set_table.sv
// Randomized set table: a set of distinct signed 32-bit values held densely
// in a 64-entry store, with insert, remove and random sample operations.
// Input channel s_axis: tuser carries the operation (insert, remove, sample),
// tdata the value and the 31-bit random word. One transaction at a time.
// Output channel m_axis: tuser carries the status, tdata the sampled value
// and the entry count after the operation. Every input transaction gives
// exactly one output transaction.
// Insert and remove scan the store one entry per cycle through the single
// read port of the entry memory; remove then reads the last entry and
// moves it into the freed slot. Sample reduces the random word modulo the
// count with a radix-2 divider, one bit per cycle, then one memory read.
// Reset empties the set at once; stored values are not cleared.
// The result sits in an output register; while the receiver stalls the
// block still finishes the next operation and then holds it until the
// output register frees.
module randomized_set_table import rset_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  logic [SInW-1:0]  s_axis_tdata_i,   // item_value[31:0], random_word[62:32]
  input  logic [1:0]       s_axis_tuser_i,   // op[1:0]
  output logic             m_axis_tvalid_o,
  input  logic             m_axis_tready_i,
  output logic [MOutW-1:0] m_axis_tdata_o,   // sampled_value[31:0], entry_count[38:32]
  output logic [2:0]       m_axis_tuser_o    // status[2:0]
);

  cmd_t cmd;
  sts_t sts;

  rset_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid_i,
    .s_axis_tready_o,
    .op_i  (s_axis_tuser_i),
    .sts_i (sts),
    .cmd_o (cmd)
  );

  rset_dp u_dp (
    .clk_i,
    .rst_ni,
    .cmd_i         (cmd),
    .sts_o         (sts),
    .item_value_i  (s_axis_tdata_i[ValW-1:0]),
    .random_word_i (s_axis_tdata_i[ValW+RndW-1:ValW]),
    .m_axis_tvalid_o,
    .m_axis_tready_i,
    .m_axis_tdata_o,
    .m_axis_tuser_o
  );

endmodule

### tb/set_table_checker.sv
module set_table_checker import rset_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid_i,
  input  logic             s_axis_tready_i,
  input  logic [SInW-1:0]  s_axis_tdata_i,   // item_value[31:0], random_word[62:32]
  input  logic [1:0]       s_axis_tuser_i,   // op[1:0]
  input  logic             m_axis_tvalid_i,
  input  logic             m_axis_tready_i,
  input  logic [MOutW-1:0] m_axis_tdata_i,   // sampled_value[31:0], entry_count[38:32]
  input  logic [2:0]       m_axis_tuser_i,   // status[2:0]
  output int               fail_count_o,
  output int               pending_o,
  output int               items_o,
  output int               full_hits_o,
  output int               empty_hits_o,
  output int               dup_hits_o,
  output int               miss_hits_o,
  output int               peak_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    status_e     status;
    logic [31:0] sampled;
    logic [6:0]  count;
  } set_result_t;

  logic [ValW-1:0] entries [Capacity];
  int unsigned     live_count = 0;
  set_result_t     expected_q [$];

  int mismatches = 0;
  int waiting    = 0;
  int items      = 0;
  int full_hits  = 0;
  int empty_hits = 0;
  int dup_hits   = 0;
  int miss_hits  = 0;
  int peak_count = 0;

  assign fail_count_o = mismatches;
  assign pending_o    = waiting;
  assign items_o      = items;
  assign full_hits_o  = full_hits;
  assign empty_hits_o = empty_hits;
  assign dup_hits_o   = dup_hits;
  assign miss_hits_o  = miss_hits;
  assign peak_count_o = peak_count;

  function automatic int unsigned locate(logic [ValW-1:0] value);
    for (int unsigned i = 0; i < live_count; i++) begin
      if (entries[i] == value) return i;
    end
    return live_count;
  endfunction

  function automatic set_result_t apply_op(logic [1:0] op, logic [ValW-1:0] value,
                                           logic [RndW-1:0] rnd);
    set_result_t res;
    int unsigned slot;
    res.status  = StOk;
    res.sampled = '0;
    case (op)
      OpInsert: begin
        slot = locate(value);
        if (slot < live_count) begin
          res.status = StPresent;
        end else if (live_count >= Capacity) begin
          res.status = StFull;
        end else begin
          entries[live_count] = value;
          live_count++;
        end
      end
      OpRemove: begin
        slot = locate(value);
        if (slot >= live_count) begin
          res.status = StAbsent;
        end else begin
          entries[slot] = entries[live_count - 1];
          live_count--;
        end
      end
      OpSample: begin
        if (live_count == 0) begin
          res.status = StEmpty;
        end else begin
          res.sampled = entries[rnd % live_count];
        end
      end
      default: ;
    endcase
    res.count = live_count[6:0];
    case (res.status)
      StFull:    full_hits++;
      StEmpty:   empty_hits++;
      StPresent: dup_hits++;
      StAbsent:  miss_hits++;
      default: ;
    endcase
    if (live_count > peak_count) peak_count = live_count;
    return res;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i) begin
    set_result_t want;
    set_result_t next_res;
    if (rst_ni) begin
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        if (expected_q.size() == 0) begin
          $error("unexpected result transaction: status %0d, data 0x%0h",
                 m_axis_tuser_i, m_axis_tdata_i);
          mismatches++;
        end else begin
          want = expected_q.pop_front();
          check_field("status", 32'(want.status), 32'(m_axis_tuser_i));
          check_field("sampled_value", want.sampled, m_axis_tdata_i[31:0]);
          check_field("entry_count", 32'(want.count), 32'(m_axis_tdata_i[38:32]));
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        next_res   = apply_op(s_axis_tuser_i, s_axis_tdata_i[31:0], s_axis_tdata_i[62:32]);
        expected_q = {expected_q, next_res};
        items++;
      end
      waiting = expected_q.size();
    end
  end

endmodule

### tb/tb_randomized_set_table.sv
module tb_randomized_set_table import rset_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] OpUnused = 2'd3;
  localparam int ResetCycles   = 7;
  localparam int RandomItems   = 1250;
  localparam int PoolSize      = 80;
  localparam int HoldCycles    = 400;
  localparam int DrainCycles   = 100;
  localparam int WatchdogLimit = 4000;

  typedef enum int {MixFill, MixDrain, MixBoth} mix_e;

  logic             clk_i    = 1'b0;
  logic             rst_ni   = 1'b0;
  logic             s_tvalid = 1'b0;
  logic [SInW-1:0]  s_tdata  = '0;
  logic [1:0]       s_tuser  = '0;
  logic             m_tready = 1'b0;
  logic             s_axis_tready_o;
  logic             m_axis_tvalid_o;
  logic [MOutW-1:0] m_axis_tdata_o;
  logic [2:0]       m_axis_tuser_o;

  logic             hold_req = 1'b0;
  logic             no_idle  = 1'b0;
  int               idle_cycles = 0;
  logic [ValW-1:0]  value_pool [PoolSize];

  int fails, pending, items, full_hits, empty_hits, dup_hits, miss_hits, peak_count;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  randomized_set_table dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  set_table_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_i (s_axis_tready_o),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_i (m_axis_tvalid_o),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_i  (m_axis_tdata_o),
    .m_axis_tuser_i  (m_axis_tuser_o),
    .fail_count_o    (fails),
    .pending_o       (pending),
    .items_o         (items),
    .full_hits_o     (full_hits),
    .empty_hits_o    (empty_hits),
    .dup_hits_o      (dup_hits),
    .miss_hits_o     (miss_hits),
    .peak_count_o    (peak_count)
  );

  function automatic int pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 20);
    return $urandom_range(30, 120);
  endfunction

  function automatic logic [1:0] pick_op(mix_e mode);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 3) return OpUnused;
    case (mode)
      MixFill:  return roll < 70 ? OpInsert : (roll < 85 ? OpSample : OpRemove);
      MixDrain: return roll < 65 ? OpRemove : (roll < 85 ? OpSample : OpInsert);
      default:  return roll < 40 ? OpInsert : (roll < 75 ? OpRemove : OpSample);
    endcase
  endfunction

  function automatic logic [ValW-1:0] pick_value();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 80) return value_pool[$urandom_range(0, PoolSize - 1)];
    return $urandom();
  endfunction

  function automatic logic [RndW-1:0] pick_random_word();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 8) return '0;
    if (roll < 16) return '1;
    if (roll < 40) return 31'($urandom_range(0, 200));
    return 31'($urandom());
  endfunction

  task automatic send_op(logic [1:0] op, logic [ValW-1:0] value, logic [RndW-1:0] rnd);
    int gap;
    gap = no_idle ? 0 : pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {1'b0, rnd, value};
    do @(posedge clk_i); while (!s_axis_tready_o);
  endtask

  // drop the result channel's ready at random; hold it off once for a long stretch
  initial begin : receiver
    int  n;
    bit  hold_done;
    hold_done = 1'b0;
    do @(posedge clk_i); while (!rst_ni);
    forever begin
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        m_tready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
      end else if (no_idle) begin
        m_tready <= 1'b1;
        @(posedge clk_i);
      end else begin
        n = pick_gap();
        if (n > 0) begin
          m_tready <= 1'b0;
          repeat (n) @(posedge clk_i);
        end
        m_tready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_tvalid && s_axis_tready_o) || (m_axis_tvalid_o && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WatchdogLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin : stimulus
    int   sent;
    int   seg;
    int   seg_len;
    mix_e mode;
    value_pool[0] = 32'h8000_0000;
    value_pool[1] = 32'h7FFF_FFFF;
    value_pool[2] = 32'h0000_0000;
    value_pool[3] = 32'hFFFF_FFFF;
    for (int i = 4; i < PoolSize; i++) value_pool[i] = $urandom();

    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty store corner cases
    send_op(OpSample, 32'h0000_0005, 31'd5);
    send_op(OpRemove, 32'h0000_0007, '0);
    send_op(OpUnused, 32'hFFFF_FFFF, '1);
    // extremes of the value range, then a duplicate
    send_op(OpInsert, 32'h8000_0000, '0);
    send_op(OpInsert, 32'h7FFF_FFFF, '1);
    send_op(OpInsert, 32'h0000_0000, '0);
    send_op(OpInsert, 32'hFFFF_FFFF, '0);
    send_op(OpInsert, 32'h7FFF_FFFF, '0);
    send_op(OpSample, 32'h1234_5678, '0);
    send_op(OpSample, 32'h0000_0000, '1);
    send_op(OpSample, 32'h0000_0000, 31'd2);
    send_op(OpSample, 32'h0000_0000, 31'd3);
    // remove the first entry so the last one moves into its slot
    send_op(OpRemove, 32'h8000_0000, '0);
    send_op(OpSample, 32'h0000_0000, '0);
    send_op(OpRemove, 32'h0000_0000, '0);
    send_op(OpRemove, 32'h0001_2345, '0);
    send_op(OpUnused, 32'h7FFF_FFFF, '1);
    send_op(OpRemove, 32'h7FFF_FFFF, '0);
    send_op(OpRemove, 32'hFFFF_FFFF, '0);
    send_op(OpSample, 32'hFFFF_FFFF, '1);

    sent = 0;
    seg  = 0;
    while (sent < RandomItems) begin
      mode    = (seg == 0) ? MixFill : mix_e'($urandom_range(0, 2));
      seg_len = $urandom_range(20, 100);
      if (seg == 1) hold_req <= 1'b1;
      if (seg == 3) no_idle <= 1'b1;
      else if (seg == 4) no_idle <= 1'b0;
      for (int k = 0; k < seg_len; k++) begin
        send_op(pick_op(mode), pick_value(), pick_random_word());
      end
      sent += seg_len;
      seg++;
    end
    s_tvalid <= 1'b0;

    do @(negedge clk_i); while (pending != 0);
    repeat (DrainCycles) @(negedge clk_i);

    $display("Ran %0d operations: %0d inserts into a full store, %0d samples of an empty one,",
             items, full_hits, empty_hits);
    $display("%0d duplicate inserts, %0d removes of absent values, peak occupancy %0d of %0d.",
             dup_hits, miss_hits, peak_count, Capacity);
    if (fails == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

### files.f
design/rset_pkg.sv
design/rset_dp.sv
design/rset_ctrl.sv
design/randomized_set_table.sv
tb/set_table_checker.sv
tb/tb_randomized_set_table.sv
